>>> hdl/kgrbp_pkg.sv
// Shared constants, types and width helpers for the keyframe gap-rate best picker.
package kgrbp_pkg;

  localparam int LEN_W         = 24;
  localparam int SCORE_W       = 64;
  localparam int SCALE_W       = 20;
  localparam int POS_BITS_DEF  = 48;
  localparam int TIME_BITS_DEF = 40;

  localparam logic [SCALE_W-1:0] SCALE     = 20'd1000000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Operation codes carried on the input channel.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // Width of the end-of-previous-frame sum (position plus length, one carry bit).
  function automatic int sum_w(int pos_bits);
    return ((pos_bits > LEN_W) ? pos_bits : LEN_W) + 1;
  endfunction

  // Width of the scaled numerator magnitude, which is also the quotient width.
  function automatic int prod_w(int pos_bits);
    return sum_w(pos_bits) + SCALE_W;
  endfunction

  typedef struct packed {
    logic capture;
    logic mul_step;
    logic div_step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic out_free;
    logic prev_valid;
  } dp_sts_t;

endpackage

>>> hdl/kgrbp_if.sv
// Valid/ready channel interfaces for frame items and pick results.
interface kgrbp_in_if
  import kgrbp_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [POS_BITS-1:0]  frame_pos;
  logic [LEN_W-1:0]     frame_len;
  logic [TIME_BITS-1:0] frame_usec;

  modport source (output valid, operation, frame_pos, frame_len, frame_usec, input ready);
  modport sink   (input valid, operation, frame_pos, frame_len, frame_usec, output ready);
endinterface

interface kgrbp_out_if
  import kgrbp_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [POS_BITS-1:0]  best_pos;
  logic [LEN_W-1:0]     best_len;
  logic [TIME_BITS-1:0] best_usec;

  modport source (output valid, found, best_pos, best_len, best_usec, input ready);
  modport sink   (input valid, found, best_pos, best_len, best_usec, output ready);
endinterface

>>> hdl/kgrbp_ctrl.sv
// Controller state machine: sequences capture, multiply, divide, commit and emit.
module kgrbp_ctrl
  import kgrbp_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  input  dp_sts_t   sts_i,
  output logic      in_ready_o,
  output ctrl_cmd_t cmd_o
);

  localparam int PROD_W = prod_w(POS_BITS);
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_COMMIT,
    S_HOLD
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_SELECT) begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
            end else begin
              state_d = S_HOLD;
            end
          end else begin
            cmd_o.capture = 1'b1;
            if (sts_i.pair_ok) begin
              state_d = S_MUL;
              cnt_d   = CNT_W'(SCALE_W - 1);
            end
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DIV;
          cnt_d   = CNT_W'(PROD_W - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_COMMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hdl/kgrbp_dp.sv
// Datapath: frame registers, shift-add scaler, restoring divider and best-score tracking.
module kgrbp_dp
  import kgrbp_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_sts_t              sts_o,
  input  logic [POS_BITS-1:0]  in_pos_i,
  input  logic [LEN_W-1:0]     in_len_i,
  input  logic [TIME_BITS-1:0] in_usec_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 out_found_o,
  output logic [POS_BITS-1:0]  out_pos_o,
  output logic [LEN_W-1:0]     out_len_o,
  output logic [TIME_BITS-1:0] out_usec_o
);

  localparam int SUM_W  = sum_w(POS_BITS);
  localparam int PROD_W = prod_w(POS_BITS);
  localparam int QX_W   = (PROD_W > SCORE_W + 1) ? PROD_W : SCORE_W + 1;

  // Control state, reset.
  logic               prev_valid_q;
  logic               best_valid_q;
  logic [SCORE_W-1:0] best_score_q;
  logic               out_valid_q;

  // Payload and work registers, no reset.
  logic [POS_BITS-1:0]  prev_pos_q, cand_pos_q, best_pos_q, out_pos_q;
  logic [LEN_W-1:0]     prev_len_q, cand_len_q, best_len_q, out_len_q;
  logic [TIME_BITS-1:0] prev_usec_q, cand_usec_q, best_usec_q, out_usec_q;
  logic                 out_found_q;
  logic [SUM_W-1:0]     mag_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [PROD_W-1:0]    pq_q;
  logic [TIME_BITS-1:0] rem_q, den_q;
  logic                 neg_q;

  // Operand preparation for a new pair.
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W:0]       diff, diff_neg;
  logic                 num_neg;
  logic [SUM_W-1:0]     num_mag;
  logic                 den_neg;
  logic [TIME_BITS-1:0] den_mag;

  always_comb begin
    end_sum  = SUM_W'(prev_pos_q) + SUM_W'(prev_len_q);
    diff     = (SUM_W + 1)'(in_pos_i) - (SUM_W + 1)'(end_sum);
    diff_neg = (SUM_W + 1)'(0) - diff;
    num_neg  = diff[SUM_W];
    num_mag  = num_neg ? diff_neg[SUM_W-1:0] : diff[SUM_W-1:0];
    den_neg  = in_usec_i < prev_usec_q;
    den_mag  = den_neg ? (prev_usec_q - in_usec_i) : (in_usec_i - prev_usec_q);
  end

  // One shift-add step of the scale multiply and one restoring division step.
  logic [PROD_W-1:0]    mul_next;
  logic [TIME_BITS:0]   rem_shift, rem_sub;
  logic                 rem_ge;

  always_comb begin
    mul_next  = {pq_q[PROD_W-2:0], 1'b0}
              + (scale_q[SCALE_W-1] ? PROD_W'(mag_q) : PROD_W'(0));
    rem_shift = {rem_q, pq_q[PROD_W-1]};
    rem_ge    = rem_shift >= {1'b0, den_q};
    rem_sub   = rem_shift - {1'b0, den_q};
  end

  // Signed, saturated score from the quotient magnitude.
  logic [QX_W-1:0]    q_ext;
  logic [SCORE_W-1:0] score;
  logic               better;

  always_comb begin
    q_ext = QX_W'(pq_q);
    if (!neg_q) begin
      score = (q_ext > QX_W'(SCORE_MAX)) ? SCORE_MAX : q_ext[SCORE_W-1:0];
    end else begin
      score = (q_ext > QX_W'(SCORE_MIN)) ? SCORE_MIN
                                          : SCORE_W'(0) - q_ext[SCORE_W-1:0];
    end
    better = $signed(score) > $signed(best_score_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      best_valid_q <= 1'b0;
      best_score_q <= SCORE_MIN;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        prev_valid_q <= 1'b1;
      end
      if (cmd_i.commit && better) begin
        best_valid_q <= 1'b1;
        best_score_q <= score;
      end
      if (cmd_i.emit) begin
        prev_valid_q <= 1'b0;
        best_valid_q <= 1'b0;
        best_score_q <= SCORE_MIN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cand_pos_q  <= prev_pos_q;
      cand_len_q  <= prev_len_q;
      cand_usec_q <= prev_usec_q;
      prev_pos_q  <= in_pos_i;
      prev_len_q  <= in_len_i;
      prev_usec_q <= in_usec_i;
      mag_q       <= num_mag;
      den_q       <= den_mag;
      neg_q       <= num_neg ^ den_neg;
      scale_q     <= SCALE;
      pq_q        <= '0;
      rem_q       <= '0;
    end
    if (cmd_i.mul_step) begin
      pq_q    <= mul_next;
      scale_q <= {scale_q[SCALE_W-2:0], 1'b0};
    end
    if (cmd_i.div_step) begin
      pq_q  <= {pq_q[PROD_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
    end
    if (cmd_i.commit && better) begin
      best_pos_q  <= cand_pos_q;
      best_len_q  <= cand_len_q;
      best_usec_q <= cand_usec_q;
    end
    if (cmd_i.emit) begin
      out_found_q <= best_valid_q;
      out_pos_q   <= best_valid_q ? best_pos_q : '0;
      out_len_q   <= best_valid_q ? best_len_q : '0;
      out_usec_q  <= best_valid_q ? best_usec_q : '0;
    end
  end

  assign sts_o.pair_ok    = prev_valid_q && (in_usec_i != prev_usec_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.prev_valid = prev_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;
  assign out_len_o   = out_len_q;
  assign out_usec_o  = out_usec_q;

endmodule

>>> hdl/keyframe_gap_rate_best_picker.sv
// Top level of the keyframe gap-rate best picker: controller, datapath and checks.
//
// Each record item on frame_i is a keyframe (position, length, timestamp). For every two
// consecutive records with different timestamps the block rates the gap between the end of
// the earlier frame and the start of the later one as 1000000 * gap / time difference, a
// signed quotient truncated toward zero and saturated to 64 bits, and it remembers the earlier
// frame of the pair with the strictly highest rate. A select item puts that frame on pick_o
// with found set (all zero with found clear when no pair was rated) and clears all history.
// A record that completes a pair occupies the block while it takes the item, runs a
// shift-add multiply by the 20-bit scale constant, runs a one-bit-per-cycle restoring divider
// for P = max(POS_BITS, 24) + 21 quotient bits, and saturates and compares the score. A record
// that completes no pair needs no further work, nor does a select whose output register is free.
// The result sits in an output register, so records keep being taken while a result waits; a
// select waits until that register is free.
module keyframe_gap_rate_best_picker
  import kgrbp_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kgrbp_in_if.sink    frame_i,
  kgrbp_out_if.source pick_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  // The controller decides per item; the datapath holds every frame and score register.
  kgrbp_ctrl #(
    .POS_BITS (POS_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_op_i    (frame_i.operation),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  kgrbp_dp #(
    .POS_BITS  (POS_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_pos_i    (frame_i.frame_pos),
    .in_len_i    (frame_i.frame_len),
    .in_usec_i   (frame_i.frame_usec),
    .out_ready_i (pick_o.ready),
    .out_valid_o (pick_o.valid),
    .out_found_o (pick_o.found),
    .out_pos_o   (pick_o.best_pos),
    .out_len_o   (pick_o.best_len),
    .out_usec_o  (pick_o.best_usec)
  );

  assign frame_i.ready = in_ready;

  logic in_accept;
  assign in_accept = frame_i.valid && in_ready;

  // A select taken while the output register is free shows its result on the next cycle.
  a_select_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (frame_i.operation == OP_SELECT) && sts.out_free |=> pick_o.valid)
    else $error("select item did not produce a result");

  // A select clears the history, so the next record cannot form a pair.
  a_select_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (frame_i.operation == OP_SELECT) && sts.out_free |=> !sts.prev_valid)
    else $error("previous frame survived a select");

  // A record that completes a pair keeps the block busy while the score is computed.
  a_pair_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (frame_i.operation == OP_RECORD) && sts.pair_ok |=> !in_ready ##1 !in_ready)
    else $error("new item taken during score computation");

  // After any record the previous frame is held.
  a_record_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (frame_i.operation == OP_RECORD) |=> sts.prev_valid)
    else $error("record item was not kept as previous frame");

endmodule
